/* hw/rtl/fqmg_pkg.sv */
// ----------------------------------------------------------------------------
// fqmg_pkg - shared types and constants for the frame queue gap dropper
// Item kinds, status codes, stream widths and the controller/datapath link.
// ----------------------------------------------------------------------------
package fqmg_pkg;

  localparam int unsigned PTS_W       = 64;
  localparam int unsigned EXT_HND_W   = 16;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned DROPS_W     = 32;
  localparam int unsigned QUEUED_W    = 4;
  localparam int unsigned IN_DATA_W   = 80;   // handle + pts
  localparam int unsigned OUT_DATA_W  = 136;  // 132 used bits, padded to bytes
  localparam int unsigned OUT_USER_W  = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME     = 3'd0,
    KIND_REQUEST   = 3'd1,
    KIND_PLAY      = 3'd2,
    KIND_STOP      = 3'd3,
    KIND_FLUSH     = 3'd4,
    KIND_FLUSH_EOS = 3'd5,
    KIND_START     = 3'd6
  } kind_t;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CHANGED  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load_in;      // capture accepted item, clear result fields
    logic append;       // write captured frame at the tail
    logic set_rejected; // frame arrived while stopped
    logic ctl_apply;    // play / stop / flush / flush eos / start
    logic scan_init;    // restart gap search
    logic scan_rd;      // read next entry for the gap search
    logic shift_init;   // start closing the hole at the chosen entry
    logic shift_rd;     // read entry above the hole, write-back follows
    logic drop_done;    // shrink queue, bump drop counter
    logic req_rd;       // read head entry
    logic req_take;     // hand out head entry, pop it
    logic emit;         // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  stopped;
    logic  empty;
    logic  over_limit;
    logic  scan_last;
    logic  scan_busy;
    logic  shift_more;
    logic  out_free;
  } stat_t;

endpackage

/* hw/rtl/fqmg_ram.sv */
// ----------------------------------------------------------------------------
// fqmg_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fqmg_ram #(
  parameter int unsigned DW    = 80,
  parameter int unsigned DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/fqmg_ctrl.sv */
// ----------------------------------------------------------------------------
// fqmg_ctrl - sequencer for the frame queue gap dropper
// Walks each item through append, gap scan, hole close, request pop or control update.
// ----------------------------------------------------------------------------
module fqmg_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  fqmg_pkg::stat_t stat,
  output fqmg_pkg::cmd_t  cmd,
  output logic            in_ready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHECK,
    S_SCAN,
    S_SCAN_WAIT,
    S_SHIFT,
    S_DRAIN,
    S_REQ_TAKE,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_RESULT;
        case (stat.kind)
          fqmg_pkg::KIND_FRAME: begin
            if (stat.stopped) begin
              cmd.set_rejected = 1'b1;
            end else begin
              cmd.append = 1'b1;
              state_nxt  = S_CHECK;
            end
          end
          fqmg_pkg::KIND_REQUEST: begin
            if (!stat.empty) begin
              cmd.req_rd = 1'b1;
              state_nxt  = S_REQ_TAKE;
            end
          end
          default: begin
            cmd.ctl_apply = 1'b1;
          end
        endcase
      end
      S_CHECK: begin
        if (stat.over_limit) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        if (!stat.scan_busy) begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_more) begin
          cmd.shift_rd = 1'b1;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.drop_done = 1'b1;
        state_nxt     = S_RESULT;
      end
      S_REQ_TAKE: begin
        cmd.req_take = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

/* hw/rtl/fqmg_dp.sv */
// ----------------------------------------------------------------------------
// fqmg_dp - datapath for the frame queue gap dropper
// Ring-buffered entry RAM, gap search pipeline, counters and output register.
// ----------------------------------------------------------------------------
module fqmg_dp #(
  parameter int unsigned MAX_FRAMES  = 8,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fqmg_pkg::cmd_t                      cmd,
  output fqmg_pkg::stat_t                     stat,
  input  logic [fqmg_pkg::KIND_W-1:0]         in_kind,
  input  logic [fqmg_pkg::EXT_HND_W-1:0]      in_handle,
  input  logic [fqmg_pkg::PTS_W-1:0]          in_pts,
  input  logic                                cfg_we,
  input  logic [fqmg_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [fqmg_pkg::OUT_USER_W-1:0]     out_user,
  output logic [fqmg_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int unsigned DEPTH = MAX_FRAMES + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned PW    = fqmg_pkg::PTS_W;
  localparam int unsigned DW    = PW + HANDLE_BITS;

  // logical queue position -> RAM address
  function automatic logic [AW-1:0] phys_of(input logic [AW-1:0]    head,
                                            input logic [CNT_W-1:0] lidx);
    logic [AW:0] sum;
    sum = {1'b0, head} + (AW+1)'(lidx);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // control state
  logic [CNT_W-1:0]               count_r;
  logic [AW-1:0]                  head_r;
  logic                           stopped_r;
  logic [fqmg_pkg::DROPS_W-1:0]   drops_r;
  logic [fqmg_pkg::CFG_W-1:0]     max_q_r;
  logic [CNT_W-1:0]               scan_idx_r;
  logic [CNT_W-1:0]               shift_idx_r;
  logic                           s1_valid_r;
  logic                           s2_valid_r;
  logic                           best_valid_r;
  logic                           wb_valid_r;
  logic                           out_valid_r;

  // payload
  fqmg_pkg::kind_t                kind_r;
  logic [HANDLE_BITS-1:0]         hnd_r;
  logic [PW-1:0]                  pts_r;
  logic [CNT_W-1:0]               s1_idx_r;
  logic [PW-1:0]                  prev_pts_r;
  logic signed [PW:0]             gap_r;
  logic [CNT_W-1:0]               s2_idx_r;
  logic [HANDLE_BITS-1:0]         s2_handle_r;
  logic signed [PW:0]             best_gap_r;
  logic [CNT_W-1:0]               best_idx_r;
  logic [HANDLE_BITS-1:0]         best_handle_r;
  logic [AW-1:0]                  wb_addr_r;
  logic [fqmg_pkg::STATUS_W-1:0]  res_status_r;
  logic                           res_ovalid_r;
  logic [fqmg_pkg::EXT_HND_W-1:0] res_ohandle_r;
  logic [PW-1:0]                  res_opts_r;
  logic                           res_dropped_r;
  logic [fqmg_pkg::EXT_HND_W-1:0] res_dhandle_r;
  logic [fqmg_pkg::OUT_USER_W-1:0] out_user_r;
  logic [fqmg_pkg::OUT_DATA_W-1:0] out_data_r;

  // RAM ports
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [DW-1:0]          wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [DW-1:0]          rd_data;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [PW-1:0]          rd_pts;

  logic [CNT_W-1:0]       limit;
  logic                   not_full;
  logic                   out_free;

  assign rd_handle = rd_data[DW-1:PW];
  assign rd_pts    = rd_data[PW-1:0];
  assign not_full  = (count_r < CNT_W'(DEPTH));
  assign out_free  = !out_valid_r || out_ready;

  // out-of-range limits are clamped to 1..MAX_FRAMES
  always_comb begin
    if (max_q_r == '0) begin
      limit = CNT_W'(1);
    end else if (32'(max_q_r) > 32'(MAX_FRAMES)) begin
      limit = CNT_W'(MAX_FRAMES);
    end else begin
      limit = CNT_W'(max_q_r);
    end
  end

  always_comb begin
    rd_en   = cmd.scan_rd || cmd.shift_rd || cmd.req_rd;
    rd_addr = head_r;
    if (cmd.scan_rd) begin
      rd_addr = phys_of(head_r, scan_idx_r);
    end else if (cmd.shift_rd) begin
      rd_addr = phys_of(head_r, CNT_W'(shift_idx_r + 1'b1));
    end
  end

  // shift write-back has the port in the cycle after its read
  always_comb begin
    wr_en   = wb_valid_r || (cmd.append && not_full);
    wr_addr = phys_of(head_r, count_r);
    wr_data = {hnd_r, pts_r};
    if (wb_valid_r) begin
      wr_addr = wb_addr_r;
      wr_data = rd_data;
    end
  end

  fqmg_ram #(
    .DW    (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    stat.kind       = kind_r;
    stat.stopped    = stopped_r;
    stat.empty      = (count_r == '0);
    stat.over_limit = (count_r > limit) && (count_r >= CNT_W'(2));
    stat.scan_last  = (scan_idx_r == CNT_W'(count_r - 1'b1));
    stat.scan_busy  = s1_valid_r || s2_valid_r;
    stat.shift_more = (CNT_W'(shift_idx_r + 1'b1) < count_r);
    stat.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      head_r       <= '0;
      stopped_r    <= 1'b0;
      drops_r      <= '0;
      max_q_r      <= fqmg_pkg::CFG_W'(1);
      scan_idx_r   <= '0;
      shift_idx_r  <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      best_valid_r <= 1'b0;
      wb_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_q_r <= cfg_wdata;
      end
      if (cmd.append && not_full) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.ctl_apply) begin
        case (kind_r) inside
          fqmg_pkg::KIND_PLAY:      stopped_r <= 1'b0;
          fqmg_pkg::KIND_STOP:      stopped_r <= 1'b1;
          fqmg_pkg::KIND_FLUSH,
          fqmg_pkg::KIND_FLUSH_EOS: count_r   <= '0;
          fqmg_pkg::KIND_START: begin
            if (!stopped_r) begin
              drops_r <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.req_take) begin
        head_r  <= phys_of(head_r, CNT_W'(1));
        count_r <= count_r - 1'b1;
      end
      if (cmd.drop_done) begin
        count_r <= count_r - 1'b1;
        if (drops_r != '1) begin
          drops_r <= drops_r + 1'b1;
        end
      end

      // gap search pipeline: read -> gap -> compare
      if (cmd.scan_init) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_rd) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      s1_valid_r <= cmd.scan_rd;
      s2_valid_r <= s1_valid_r && (s1_idx_r != '0);
      if (cmd.scan_init) begin
        best_valid_r <= 1'b0;
      end else if (s2_valid_r) begin
        best_valid_r <= 1'b1;
      end

      if (cmd.shift_init) begin
        shift_idx_r <= best_idx_r;
      end else if (cmd.shift_rd) begin
        shift_idx_r <= shift_idx_r + 1'b1;
      end
      wb_valid_r <= cmd.shift_rd;

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r        <= fqmg_pkg::kind_t'(in_kind);
      hnd_r         <= HANDLE_BITS'(32'(in_handle));
      pts_r         <= in_pts;
      res_status_r  <= fqmg_pkg::ST_OK;
      res_ovalid_r  <= 1'b0;
      res_ohandle_r <= '0;
      res_opts_r    <= '0;
      res_dropped_r <= 1'b0;
      res_dhandle_r <= '0;
    end
    if (cmd.set_rejected) begin
      res_status_r <= fqmg_pkg::ST_REJECTED;
    end
    if (cmd.ctl_apply) begin
      case (kind_r) inside
        fqmg_pkg::KIND_PLAY,
        fqmg_pkg::KIND_STOP:  res_status_r <= fqmg_pkg::ST_CHANGED;
        fqmg_pkg::KIND_START: begin
          if (stopped_r) begin
            res_status_r <= fqmg_pkg::ST_REJECTED;
          end
        end
        default: ;
      endcase
    end
    if (cmd.req_take) begin
      res_ovalid_r  <= 1'b1;
      res_ohandle_r <= fqmg_pkg::EXT_HND_W'(rd_handle);
      res_opts_r    <= rd_pts;
    end

    if (cmd.scan_rd) begin
      s1_idx_r <= scan_idx_r;
    end
    if (s1_valid_r) begin
      prev_pts_r  <= rd_pts;
      gap_r       <= $signed({rd_pts[PW-1], rd_pts}) - $signed({prev_pts_r[PW-1], prev_pts_r});
      s2_idx_r    <= s1_idx_r;
      s2_handle_r <= rd_handle;
    end
    // strict less keeps the first of equal gaps
    if (s2_valid_r && (!best_valid_r || (gap_r < best_gap_r))) begin
      best_gap_r    <= gap_r;
      best_idx_r    <= s2_idx_r;
      best_handle_r <= s2_handle_r;
    end

    if (cmd.shift_init) begin
      res_dropped_r <= 1'b1;
      res_dhandle_r <= fqmg_pkg::EXT_HND_W'(best_handle_r);
    end
    if (cmd.shift_rd) begin
      wb_addr_r <= phys_of(head_r, shift_idx_r);
    end

    if (cmd.emit) begin
      out_user_r <= {res_dropped_r, res_ovalid_r, res_status_r};
      out_data_r <= {4'b0, fqmg_pkg::QUEUED_W'(count_r), drops_r, res_dhandle_r,
                     res_opts_r, res_ohandle_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_user  = out_user_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/frame_queue_min_gap_dropper.sv */
// ----------------------------------------------------------------------------
// Flow: one item in flight. Control items and rejected frames go from dispatch
//   straight to the result; a request reads and pops the head; a frame is
//   appended and checked against the limit, and if over it the gap scan and
//   the hole close each step through the entries on the single read port of
//   the entry RAM.
// Reset: synchronous, active low; empties the queue, running, drop count 0.
// ----------------------------------------------------------------------------
// frame_queue_min_gap_dropper - video frame queue with smallest-gap dropping
// Appends frames, drops the entry with the smallest timestamp gap when over
// the limit, hands out the head on request, handles play/stop/flush/start.
// ----------------------------------------------------------------------------
module frame_queue_min_gap_dropper #(
  parameter int unsigned MAX_FRAMES  = 8,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fqmg_pkg::IN_DATA_W-1:0]      in_tdata,  // frame_handle[15:0], frame_pts[79:16]
  input  logic [fqmg_pkg::KIND_W-1:0]         in_tuser,  // kind[2:0]
  // result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fqmg_pkg::OUT_DATA_W-1:0]     out_tdata, // out_handle[15:0], out_pts[79:16],
                                                         // dropped_handle[95:80],
                                                         // drop_total[127:96], queued[131:128],
                                                         // zero pad[135:132]
  output logic [fqmg_pkg::OUT_USER_W-1:0]     out_tuser, // status[1:0], out_valid[2], dropped[3]
  // max_queued register
  input  logic                                cfg_we,
  input  logic [fqmg_pkg::CFG_W-1:0]          cfg_wdata
);

  fqmg_pkg::cmd_t  cmd;
  fqmg_pkg::stat_t stat;

  // Sequencer: one item at a time, in_tready high only while idle. The
  // result sits in an output register so the next item can be taken while
  // the previous result still waits downstream.
  fqmg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  // Datapath: entries live in a ring buffer in RAM (MAX_FRAMES + 1 deep),
  // so a request pops the head by moving the head pointer. A drop scans the
  // gaps through a read/gap/compare pipeline, then closes the hole by moving
  // later entries down one place, one read and one write per cycle.
  fqmg_dp #(
    .MAX_FRAMES  (MAX_FRAMES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (in_tuser),
    .in_handle (in_tdata[15:0]),
    .in_pts    (in_tdata[79:16]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_user  (out_tuser),
    .out_data  (out_tdata)
  );

endmodule
